FILE: design/shac_pkg.sv
// Shared types, constants and round functions for the SHA-512 family hash core.
// No dependencies; shac_front, shac_back and the top level import this package.
`timescale 1ns / 1ps

package shac_pkg;

  localparam int ROUNDS      = 80;
  localparam int BLOCK_WORDS = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] MODE_SHA512     = 2'd0;
  localparam logic [1:0] MODE_SHA384     = 2'd1;
  localparam logic [1:0] MODE_SHA512_256 = 2'd2;
  localparam logic [1:0] MODE_SHA512_224 = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_ROUND,
    ST_FINISH,
    ST_PAD,
    ST_DIGEST
  } back_state_t;

  // one classified message word: bytes past nbytes already zeroed
  typedef struct packed {
    logic [63:0] word;
    logic [3:0]  nbytes;
    logic        last;
  } item_t;

  // handshake between the front queue and the back end
  typedef struct packed {
    logic valid;
    logic ready;
  } link_t;

  localparam logic [63:0] ROUND_K [ROUNDS] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  localparam logic [63:0] START_VALUES [4][8] = '{
    '{64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
      64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179},
    '{64'hcbbb9d5dc1059ed8, 64'h629a292a367cd507, 64'h9159015a3070dd17, 64'h152fecd8f70e5939,
      64'h67332667ffc00b31, 64'h8eb44a8768581511, 64'hdb0c2e0d64f98fa7, 64'h47b5481dbefa4fa4},
    '{64'h22312194fc2bf72c, 64'h9f555fa3c84c64c2, 64'h2393b86b6f53b151, 64'h963877195940eabd,
      64'h96283ee2a88effe3, 64'hbe5e1e2553863992, 64'h2b0199fc2c85b8aa, 64'h0eb72ddc81c52ca2},
    '{64'h8c3d37c819544da2, 64'h73e1996689dcd4d6, 64'h1dfab7ae32ff9c82, 64'h679dd514582f9fcf,
      64'h0f6d2b697bd44da8, 64'h77e36f7304c48942, 64'h3f9d85a86a1d36c8, 64'h1112e6ad91d692a1}
  };

  // index of the final digest word for a mode
  function automatic logic [2:0] digest_last_idx(input logic [1:0] mode);
    logic [2:0] idx;
    unique case (mode)
      MODE_SHA512: idx = 3'd7;
      MODE_SHA384: idx = 3'd5;
      default:     idx = 3'd3;
    endcase
    return idx;
  endfunction

  function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  function automatic logic [63:0] bsig0(input logic [63:0] x);
    return rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
  endfunction

  function automatic logic [63:0] bsig1(input logic [63:0] x);
    return rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
  endfunction

  function automatic logic [63:0] ssig0(input logic [63:0] x);
    return rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
  endfunction

  function automatic logic [63:0] ssig1(input logic [63:0] x);
    return rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
  endfunction

  function automatic logic [63:0] ch(input logic [63:0] e, input logic [63:0] f,
                                     input logic [63:0] g);
    return (e & f) ^ (~e & g);
  endfunction

  function automatic logic [63:0] maj(input logic [63:0] a, input logic [63:0] b,
                                      input logic [63:0] c);
    return (a & b) ^ (a & c) ^ (b & c);
  endfunction

endpackage

FILE: design/shac_if.sv
// Channel interfaces of the hash core: message words in, digest words out.
// No dependencies.
`timescale 1ns / 1ps

interface shac_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] message_word;
  logic [3:0]  valid_bytes;
  logic        last_word;

  modport source(output valid, message_word, valid_bytes, last_word, input ready);
  modport sink(input valid, message_word, valid_bytes, last_word, output ready);
endinterface

interface shac_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_word;
  logic        digest_last;

  modport source(output valid, digest_word, digest_last, input ready);
  modport sink(input valid, digest_word, digest_last, output ready);
endinterface

FILE: design/shac_front.sv
// Front end: accepts message words, clamps the byte count, zeroes unused bytes
// and queues the result. Depends on shac_pkg and shac_if.
`timescale 1ns / 1ps

module shac_front
  import shac_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  shac_in_if.sink    msg,
  output link_t      q_link_out,
  input  logic       q_ready,
  output item_t      q_item
);

  item_t              queue [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic [3:0]         nbytes;
  item_t              item_in;
  logic               push;
  logic               pop;

  always_comb begin
    nbytes = (msg.valid_bytes > 4'd8) ? 4'd8 : msg.valid_bytes;
    item_in.word   = msg.message_word & ~(64'hffff_ffff_ffff_ffff >> {nbytes, 3'b000});
    item_in.nbytes = nbytes;
    item_in.last   = msg.last_word;
  end

  assign msg.ready        = (count != QCNT_W'(QUEUE_DEPTH));
  assign push             = msg.valid && msg.ready;
  assign q_link_out.valid = (count != '0);
  assign q_link_out.ready = q_ready;
  assign pop              = q_link_out.valid && q_ready;
  assign q_item           = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

endmodule

FILE: design/shac_back.sv
// Back end: byte packer, message schedule shift line, round engine, padding
// sequencer and digest output register. Depends on shac_pkg.
`timescale 1ns / 1ps

module shac_back
  import shac_pkg::*;
#(
  parameter int LENGTH_BITS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_mode,
  input  logic [1:0]  hash_mode,
  input  logic        q_valid,
  output logic        q_ready,
  input  item_t       q_item,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_word,
  output logic        out_last
);

  back_state_t state, state_next;

  logic [63:0]            acc;
  logic [2:0]             acc_cnt;
  logic [4:0]             word_cnt;
  logic [63:0]            sched [BLOCK_WORDS];
  logic [63:0]            v  [8];
  logic [63:0]            cv [8];
  logic [6:0]             rnd;
  logic [LENGTH_BITS-1:0] byte_total;
  logic                   pad_pend;
  logic                   marker_done;
  logic                   len_phase;
  logic                   len_done;
  logic [2:0]             dig_idx;

  logic [127:0] wide;
  logic [3:0]   total;
  logic         pack_emit;
  logic [127:0] len_bits;
  logic [63:0]  pad_word;
  logic [63:0]  sched_in;
  logic [63:0]  w_new;
  logic [63:0]  w_cur;
  logic [63:0]  t1;
  logic [63:0]  t2;
  logic         q_take;
  logic         sched_shift;
  logic         dig_load;
  logic         dig_end;
  logic [2:0]   last_idx;
  logic [63:0]  dig_word;

  // packing and padding datapath
  always_comb begin
    wide      = {acc, 64'd0} | ({q_item.word, 64'd0} >> {acc_cnt, 3'b000});
    total     = {1'b0, acc_cnt} + q_item.nbytes;
    pack_emit = total[3];
    len_bits  = 128'(byte_total) << 3;
    if (!marker_done) begin
      pad_word = acc | (64'h8000_0000_0000_0000 >> {acc_cnt, 3'b000});
    end else if (word_cnt == 5'd14) begin
      pad_word = len_bits[127:64];
    end else if (word_cnt == 5'd15 && len_phase) begin
      pad_word = len_bits[63:0];
    end else begin
      pad_word = 64'd0;
    end
    sched_in = (state == ST_PAD) ? pad_word : wide[127:64];
  end

  // round datapath
  always_comb begin
    w_new = ssig1(sched[14]) + sched[9] + ssig0(sched[1]) + sched[0];
    w_cur = (rnd < 7'(BLOCK_WORDS)) ? sched[0] : w_new;
    t1    = v[7] + bsig1(v[4]) + ch(v[4], v[5], v[6]) + ROUND_K[rnd] + w_cur;
    t2    = bsig0(v[0]) + maj(v[0], v[1], v[2]);
  end

  always_comb begin
    last_idx = digest_last_idx(hash_mode);
    dig_word = cv[dig_idx];
    if (hash_mode == MODE_SHA512_224 && dig_idx == 3'd3) begin
      dig_word[31:0] = 32'd0;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          if (pack_emit && word_cnt == 5'd15) state_next = ST_START;
          else if (q_item.last)              state_next = ST_PAD;
        end
      end
      ST_START: state_next = ST_ROUND;
      ST_ROUND: begin
        if (rnd == 7'(ROUNDS - 1)) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (len_done)      state_next = ST_DIGEST;
        else if (pad_pend) state_next = ST_PAD;
        else               state_next = ST_IDLE;
      end
      ST_PAD: begin
        if (word_cnt == 5'd15) state_next = ST_START;
      end
      ST_DIGEST: begin
        if (dig_end) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    q_ready     = (state == ST_IDLE);
    q_take      = q_ready && q_valid;
    sched_shift = (q_take && pack_emit) || (state == ST_PAD);
    dig_load    = (state == ST_DIGEST) && (!out_valid || out_ready);
    dig_end     = dig_load && (dig_idx == last_idx);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // schedule shift line and round variables
  always_ff @(posedge clk) begin
    if (sched_shift || state == ST_ROUND) begin
      for (int i = 0; i < BLOCK_WORDS - 1; i++) sched[i] <= sched[i + 1];
      sched[BLOCK_WORDS - 1] <= (state == ST_ROUND) ? w_cur : sched_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) v[i] <= 64'd0;
    end else if (state == ST_START) begin
      for (int i = 0; i < 8; i++) v[i] <= cv[i];
    end else if (state == ST_ROUND) begin
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_cnt     <= '0;
      acc         <= '0;
      word_cnt    <= '0;
      rnd         <= '0;
      byte_total  <= '0;
      pad_pend    <= 1'b0;
      marker_done <= 1'b0;
      len_phase   <= 1'b0;
      len_done    <= 1'b0;
      dig_idx     <= '0;
      out_valid   <= 1'b0;
      for (int i = 0; i < 8; i++) cv[i] <= START_VALUES[MODE_SHA512][i];
    end else begin
      if (cfg_we) begin
        for (int i = 0; i < 8; i++) cv[i] <= START_VALUES[cfg_mode][i];
        byte_total <= '0;
        acc        <= '0;
        acc_cnt    <= '0;
        word_cnt   <= '0;
      end

      if (q_take) begin
        byte_total <= byte_total + LENGTH_BITS'(q_item.nbytes);
        acc        <= pack_emit ? wide[63:0] : wide[127:64];
        acc_cnt    <= total[2:0];
        if (q_item.last) pad_pend <= 1'b1;
      end

      if (state == ST_PAD) begin
        if (!marker_done) begin
          marker_done <= 1'b1;
          acc         <= '0;
          acc_cnt     <= '0;
        end else if (word_cnt == 5'd14) begin
          len_phase <= 1'b1;
        end else if (word_cnt == 5'd15 && len_phase) begin
          len_done <= 1'b1;
        end
      end

      if (sched_shift) word_cnt <= word_cnt + 1'b1;

      if (state == ST_START) rnd <= '0;
      if (state == ST_ROUND) rnd <= (rnd == 7'(ROUNDS - 1)) ? 7'd0 : rnd + 1'b1;

      if (state == ST_FINISH) begin
        for (int i = 0; i < 8; i++) cv[i] <= cv[i] + v[i];
        word_cnt <= '0;
      end

      if (dig_load) begin
        out_valid <= 1'b1;
        dig_idx   <= dig_idx + 1'b1;
        if (dig_end) begin
          dig_idx     <= '0;
          byte_total  <= '0;
          pad_pend    <= 1'b0;
          marker_done <= 1'b0;
          len_phase   <= 1'b0;
          len_done    <= 1'b0;
          for (int i = 0; i < 8; i++) cv[i] <= START_VALUES[hash_mode][i];
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dig_load) begin
      out_word <= dig_word;
      out_last <= dig_end;
    end
  end

endmodule

FILE: design/sha512_family_hash_core.sv
// SHA-512 family hash core, top level: mode register, front queue, back end.
// Depends on shac_pkg, shac_if, shac_front and shac_back.
`timescale 1ns / 1ps

// Message words enter on msg, eight big-endian bytes each; valid_bytes gives the
// leading bytes that count (above eight reads as eight) and last_word closes the
// message. Bytes pack at byte granularity into 16-word blocks. A four-entry
// queue takes words while the back end compresses, so a full block costs its
// word loads plus a load step, one round per cycle over 80 rounds and a fold
// step. The round loop limits the sustained word rate. After the last word the
// back end pads, runs one or two more compressions and hands out 8, 6 or 4
// digest words on dig, most significant first, digest_last on the final one.
// For SHA-512/224 the fourth word carries its 32 bits in the upper half. The
// output register lets the queue fill again while a digest word waits.
// hash_mode is written through cfg_valid/cfg_data; the user must write it only
// while idle, as the block itself does not enforce it. A write selects the initial
// values and starts a new message. cfg_ready is always high.

module sha512_family_hash_core
  import shac_pkg::*;
#(
  parameter int LENGTH_BITS = 64
) (
  input  logic       clk,
  input  logic       rst,
  shac_in_if.sink    msg,
  shac_out_if.source dig,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_data
);

  logic [1:0] hash_mode;
  logic       cfg_we;
  link_t      q_link;
  logic       q_ready;
  item_t      q_item;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  // mode register; the back end reloads its state on the same transaction
  always_ff @(posedge clk) begin
    if (rst)         hash_mode <= MODE_SHA512;
    else if (cfg_we) hash_mode <= cfg_data;
  end

  shac_front u_front (
    .clk        (clk),
    .rst        (rst),
    .msg        (msg),
    .q_link_out (q_link),
    .q_ready    (q_ready),
    .q_item     (q_item)
  );

  shac_back #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_mode  (cfg_data),
    .hash_mode (hash_mode),
    .q_valid   (q_link.valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .out_valid (dig.valid),
    .out_ready (dig.ready),
    .out_word  (dig.digest_word),
    .out_last  (dig.digest_last)
  );

`ifndef SYNTHESIS
  // input only stalls when the queue is full, so there must be work queued
  a_stall_means_queued: assert property (@(posedge clk) disable iff (rst)
    !msg.ready |-> q_link.valid)
    else $error("input stalled with empty queue");

  // a new digest cannot follow the final word of the previous one at once
  a_gap_after_digest: assert property (@(posedge clk) disable iff (rst)
    (dig.valid && dig.ready && dig.digest_last) |=> !dig.valid)
    else $error("digest word right after final digest word");

  // a stalled digest word stays offered and unchanged
  a_digest_held: assert property (@(posedge clk) disable iff (rst)
    (dig.valid && !dig.ready) |=> (dig.valid && $stable(dig.digest_word)
      && $stable(dig.digest_last)))
    else $error("stalled digest word changed");
`endif

endmodule

FILE: tb/tb_shac_pkg.sv
// Testbench support: SHA-512 family digest predictor and shared testbench types.
// Depends on shac_pkg for the round count and round constants.
`timescale 1ns / 1ps

package tb_shac_pkg;
  import shac_pkg::*;

  typedef struct packed {
    logic [63:0] word;
    logic        last;
  } digest_txn_t;

  function automatic logic [63:0] ror64(input logic [63:0] x, input int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  // one compression of a 16-word block into the chaining value
  function automatic void compress_block(ref logic [63:0] hv[8], input logic [63:0] blk[16]);
    logic [63:0] w[16];
    logic [63:0] v[8];
    logic [63:0] wt, t1, t2, m2, m15;
    for (int i = 0; i < 16; i++) w[i] = blk[i];
    for (int i = 0; i < 8; i++) v[i] = hv[i];
    for (int r = 0; r < ROUNDS; r++) begin
      if (r < 16) begin
        wt = w[r];
      end else begin
        m2  = w[(r - 2) & 15];
        m15 = w[(r - 15) & 15];
        wt = (ror64(m2, 19) ^ ror64(m2, 61) ^ (m2 >> 6)) + w[(r - 7) & 15]
           + (ror64(m15, 1) ^ ror64(m15, 8) ^ (m15 >> 7)) + w[r & 15];
        w[r & 15] = wt;
      end
      t1 = v[7] + (ror64(v[4], 14) ^ ror64(v[4], 18) ^ ror64(v[4], 41))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[r] + wt;
      t2 = (ror64(v[0], 28) ^ ror64(v[0], 34) ^ ror64(v[0], 39))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hv[i] = hv[i] + v[i];
  endfunction
endpackage

FILE: tb/tb_sha512_family_hash_core.sv
// Self-checking testbench for sha512_family_hash_core: message words are driven
// through shac_in_if, digests predicted in-bench and checked on shac_out_if.
// Depends on shac_pkg, shac_if, tb_shac_pkg and the design files.
`timescale 1ns / 1ps

module tb_sha512_family_hash_core;
  import shac_pkg::*;
  import tb_shac_pkg::*;

  logic clk;
  logic rst;
  logic cfg_valid;
  logic cfg_ready;
  logic [1:0] cfg_data;

  shac_in_if  msg ();
  shac_out_if dig ();

  sha512_family_hash_core dut (
    .clk(clk), .rst(rst), .msg(msg), .dig(dig),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // predictor state: mode, chaining value, partial block and byte count
  logic [1:0]  cur_mode;
  logic [63:0] chain_val[8];
  logic [63:0] blk_buf[16];
  int          blk_fill;
  logic [63:0] msg_bytes;

  digest_txn_t digest_q[$];

  int mismatches;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_cycles;       // pending long receiver stall, counted down per cycle
  int quiet_cycles;
  bit timed_out;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // restart the message with the initial values of the current mode
  function automatic void restart_msg();
    for (int i = 0; i < 8; i++) chain_val[i] = START_VALUES[cur_mode][i];
    blk_fill = 0;
    msg_bytes = '0;
  endfunction

  function automatic void pack_byte(logic [7:0] b);
    int wi;
    wi = blk_fill >> 3;
    if ((blk_fill & 7) == 0) blk_buf[wi] = '0;
    blk_buf[wi] |= 64'(b) << ((7 - (blk_fill & 7)) * 8);
    blk_fill++;
    if (blk_fill == 128) begin
      compress_block(chain_val, blk_buf);
      blk_fill = 0;
    end
  endfunction

  // absorb one accepted message word; on the last word queue the digest
  function automatic void absorb_word(logic [63:0] word, logic [3:0] nb, logic lst);
    int n;
    int nwords;
    logic [63:0] bitlen;
    digest_txn_t d;
    n = (nb > 8) ? 8 : int'(nb);
    for (int i = 0; i < n; i++) begin
      pack_byte(word[63 - 8 * i -: 8]);
      msg_bytes++;
    end
    if (!lst) return;
    bitlen = msg_bytes << 3;
    pack_byte(8'h80);
    while (blk_fill != 112) pack_byte(8'h00);
    blk_buf[14] = {61'd0, msg_bytes[63:61]};
    blk_buf[15] = bitlen;
    compress_block(chain_val, blk_buf);
    blk_fill = 0;
    nwords = int'(digest_last_idx(cur_mode)) + 1;
    for (int i = 0; i < nwords; i++) begin
      d.word = chain_val[i];
      if (cur_mode == MODE_SHA512_224 && i == 3) d.word[31:0] = '0;
      d.last = (i == nwords - 1);
      digest_q.push_back(d);
    end
    restart_msg();
  endfunction

  // one message-word transaction, with random sender gaps; valid stays up
  // after the transaction so the next word can follow without a gap
  task automatic send_word(logic [63:0] word, logic [3:0] nb, logic lst);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      msg.valid <= 1'b0;
      @(negedge clk);
    end
    msg.valid <= 1'b1;
    msg.message_word <= word;
    msg.valid_bytes <= nb;
    msg.last_word <= lst;
    do @(posedge clk); while (!msg.ready);
    absorb_word(word, nb, lst);
    @(negedge clk);
  endtask

  // wait for every digest, then let the back end drain before a mode write
  task automatic drain();
    msg.valid <= 1'b0;
    while (digest_q.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic write_mode(logic [1:0] mode);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= mode;
    do @(posedge clk); while (!cfg_ready);
    cur_mode = mode;
    restart_msg();
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // full-byte words then a last word carrying tail_bytes
  task automatic send_message(int full_words, logic [3:0] tail_bytes);
    for (int i = 0; i < full_words; i++)
      send_word({$urandom, $urandom}, 4'd8, 1'b0);
    send_word({$urandom, $urandom}, tail_bytes, 1'b1);
  endtask

  // field extremes, empty message, short words, byte counts above eight
  task automatic test_directed();
    send_word('0, 4'd0, 1'b1);
    send_word('1, 4'd8, 1'b1);
    send_word(64'h0123_4567_89ab_cdef, 4'd3, 1'b0);
    send_word('1, 4'd15, 1'b0);
    send_word(64'hfedc_ba98_7654_3210, 4'd9, 1'b1);
    send_word('0, 4'd8, 1'b0);
    send_word('1, 4'd5, 1'b0);
    send_word(64'ha5a5_5a5a_a5a5_5a5a, 4'd0, 1'b0);
    send_word('1, 4'd7, 1'b1);
    // 112-byte boundary forces a second padding block
    send_message(13, 4'd8);
    send_message(15, 4'd8);
  endtask

  // every mode, the lowest and highest codes among them
  task automatic test_modes();
    logic [1:0] order[5] = '{MODE_SHA384, MODE_SHA512_256, MODE_SHA512_224, MODE_SHA512,
                             MODE_SHA512_224};
    foreach (order[k]) begin
      write_mode(order[k]);
      send_message(1, 4'd4);
      send_message(0, 4'd0);
    end
    // write in mid-message drops the partial message
    send_word('1, 4'd8, 1'b0);
    write_mode(MODE_SHA384);
    send_message(2, 4'd1);
  endtask

  // receiver stalls long while the sender keeps offering, filling the queue
  task automatic test_backpressure();
    drain();
    hold_cycles = 400;
    send_message(1, 4'd8);
    send_message(20, 4'd6);
  endtask

  // mostly well-formed messages of random length, some odd byte counts
  task automatic test_random(int n_items);
    int sent;
    int len;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9, 0) == 0) write_mode(2'($urandom_range(3, 0)));
      len = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 16) : $urandom_range(6, 0);
      for (int i = 0; i < len; i++)
        send_word({$urandom, $urandom},
                  ($urandom_range(4, 0) == 0) ? 4'($urandom_range(15, 0)) : 4'd8, 1'b0);
      send_word({$urandom, $urandom}, 4'($urandom_range(15, 0)), 1'b1);
      sent += len + 1;
    end
  endtask

  // receiver: random ready, plus the long hold
  always @(negedge clk) begin
    if (rst) begin
      dig.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      dig.ready <= 1'b0;
    end else begin
      dig.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  // digest checker
  always @(posedge clk) begin
    digest_txn_t exp_d;
    if (!rst && dig.valid && dig.ready) begin
      if (digest_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected digest word %h last %b", dig.digest_word, dig.digest_last);
      end else begin
        exp_d = digest_q.pop_front();
        if (exp_d.word !== dig.digest_word || exp_d.last !== dig.digest_last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("digest mismatch: expected %h last %b, got %h last %b",
                     exp_d.word, exp_d.last, dig.digest_word, dig.digest_last);
        end
      end
    end
  end

  // watchdog: cycles with no transaction on any channel
  always @(posedge clk) begin
    if ((msg.valid && msg.ready) || (dig.valid && dig.ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 5000 && !timed_out) begin
      timed_out = 1'b1;
      $display("sha512_family_hash_core regression: fail");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = '0;
    msg.valid = 1'b0;
    msg.message_word = '0;
    msg.valid_bytes = '0;
    msg.last_word = 1'b0;
    dig.ready = 1'b0;
    mismatches = 0;
    hold_cycles = 0;
    quiet_cycles = 0;
    timed_out = 1'b0;
    cur_mode = MODE_SHA512;
    restart_msg();
    send_idle_pct = 6;
    recv_idle_pct = 73;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed();
    test_modes();
    test_backpressure();
    test_random(40);
    send_idle_pct = 73;
    recv_idle_pct = 6;
    test_random(40);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(40);

    drain();
    if (mismatches == 0 && digest_q.size() == 0) begin
      $display("sha512_family_hash_core regression: pass");
    end else begin
      $display("sha512_family_hash_core regression: fail");
    end
    $finish;
  end
endmodule
